>>> sv/cfq_pkg.sv
package cfq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Register port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CAP_W   = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Word index of the capacity register (paddr[2]).
    localparam logic [0:0] REG_CAP = 1'b0;

    // Operation codes.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR   = 3'd5;

    // Status codes.
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // Result flags carried from the queue core to the output register.
    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            full;
        logic            empty;
        logic            rd_ok;
    } t_s1_info;

endpackage

>>> sv/cfq_regs.sv
module cfq_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfq_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfq_pkg::PDATA_W-1:0]  pwdata,
    output logic [cfq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [cfq_pkg::CAP_W-1:0]    o_cap,
    output logic                         o_cap_wr
);
    import cfq_pkg::*;

    logic [CAP_W-1:0]       r_cap;
    logic [PADDR_W-3:0]     word_idx;
    logic                   wr_strobe;

    assign word_idx  = paddr[PADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        o_cap_wr = 1'b0;
        prdata   = '0;
        unique case (word_idx)
            REG_CAP: begin
                o_cap_wr = wr_strobe;
                prdata   = PDATA_W'(r_cap);
            end
            default: begin
                o_cap_wr = 1'b0;
                prdata   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (o_cap_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign o_cap = r_cap;

endmodule

>>> sv/cfq_core.sv
module cfq_core #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = cfq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cfq_pkg::CAP_W-1:0]    i_cap,
    input  logic                         i_cap_wr,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [cfq_pkg::OP_W-1:0]     i_operation,
    input  logic [ELEM_WIDTH-1:0]        i_data_in,
    input  logic [$clog2(DEPTH)-1:0]     i_position,
    output logic                         o_s1_valid,
    input  logic                         i_s1_stall,
    output cfq_pkg::t_s1_info            o_s1_info,
    output logic [$clog2(DEPTH+1)-1:0]   o_s1_count,
    output logic [$clog2(DEPTH+1)-1:0]   o_s1_free,
    output logic [ELEM_WIDTH-1:0]        o_s1_data
);
    import cfq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    logic [PTR_W-1:0]      r_head, r_tail;
    logic                  r_full;
    logic [CNT_W-1:0]      r_count;
    logic                  r_s1_valid;
    t_s1_info              r_s1_info;
    logic [CNT_W-1:0]      r_s1_count, r_s1_free;
    logic [ELEM_WIDTH-1:0] r_rd_data;

    logic [PTR_W-1:0]      n_head, n_tail;
    logic                  n_full;
    logic [CNT_W-1:0]      n_count;

    logic [CMP_W-1:0]      cap_x;
    logic [CNT_W-1:0]      cap_use;
    logic [SUM_W-1:0]      cap_s, head_inc, tail_inc, pos_sum;
    logic [PTR_W-1:0]      head_nx, tail_nx, tail_prev, pos_slot;
    logic                  is_empty, no_room, pos_bad;
    logic                  acc, wr_en, rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [ST_W-1:0]       status;

    // Capacity in use: zero acts as one, anything above DEPTH acts as DEPTH.
    always_comb begin
        cap_x = CMP_W'(i_cap);
        if (cap_x == '0) begin
            cap_use = CNT_W'(1);
        end else if (cap_x > CMP_W'(DEPTH)) begin
            cap_use = CNT_W'(DEPTH);
        end else begin
            cap_use = cap_x[CNT_W-1:0];
        end
    end

    // Pointer arithmetic; pointers always stay below the capacity in use.
    always_comb begin
        cap_s     = SUM_W'(cap_use);
        head_inc  = {1'b0, r_head} + SUM_W'(1);
        tail_inc  = {1'b0, r_tail} + SUM_W'(1);
        head_nx   = (head_inc >= cap_s) ? '0 : head_inc[PTR_W-1:0];
        tail_nx   = (tail_inc >= cap_s) ? '0 : tail_inc[PTR_W-1:0];
        tail_prev = (r_tail == '0) ? PTR_W'(cap_use - CNT_W'(1)) : r_tail - PTR_W'(1);
        pos_sum   = {1'b0, r_head} + SUM_W'(i_position);
        if (pos_sum >= cap_s) begin
            pos_sum = pos_sum - cap_s;
        end
        pos_slot  = pos_sum[PTR_W-1:0];
        is_empty  = (r_count == '0);
        no_room   = r_full || (r_count >= cap_use);
        pos_bad   = SUM_W'(i_position) >= SUM_W'(r_count);
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_full  = r_full;
        n_count = r_count;
        status  = ST_OK;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_head;
        unique case (i_operation)
            OP_ENQ: begin
                if (no_room) begin
                    status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_tail  = tail_nx;
                    n_count = r_count + CNT_W'(1);
                    n_full  = (n_count == cap_use);
                end
            end
            OP_DEQ: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_head  = head_nx;
                    n_count = r_count - CNT_W'(1);
                    n_full  = 1'b0;
                end
            end
            OP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            OP_REAR: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = tail_prev;
                end
            end
            OP_READ: begin
                if (pos_bad) begin
                    status = ST_RANGE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = pos_slot;
                end
            end
            OP_CLR: begin
                n_head  = '0;
                n_tail  = '0;
                n_full  = 1'b0;
                n_count = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign o_stall = r_s1_valid && i_s1_stall;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_full  <= 1'b0;
            r_count <= '0;
        end else if (i_cap_wr) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_full  <= 1'b0;
            r_count <= '0;
        end else if (acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_full  <= n_full;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (!i_s1_stall) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_info.status <= status;
            r_s1_info.full   <= (n_count == cap_use);
            r_s1_info.empty  <= (n_count == '0);
            r_s1_info.rd_ok  <= rd_en;
            r_s1_count       <= n_count;
            r_s1_free        <= cap_use - n_count;
        end
    end

    // Ring storage: one write port at the tail, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            mem[r_tail] <= i_data_in;
        end
        if (acc && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_info  = r_s1_info;
    assign o_s1_count = r_s1_count;
    assign o_s1_free  = r_s1_free;
    assign o_s1_data  = r_rd_data;

endmodule

>>> sv/cfq_out.sv
module cfq_out #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = cfq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s1_valid,
    output logic                         o_s1_stall,
    input  cfq_pkg::t_s1_info            i_s1_info,
    input  logic [$clog2(DEPTH+1)-1:0]   i_s1_count,
    input  logic [$clog2(DEPTH+1)-1:0]   i_s1_free,
    input  logic [ELEM_WIDTH-1:0]        i_s1_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cfq_pkg::ST_W-1:0]     o_status,
    output logic [ELEM_WIDTH-1:0]        o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [$clog2(DEPTH+1)-1:0]   o_free_space,
    output logic                         o_is_full_flag,
    output logic                         o_is_empty_flag
);
    import cfq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  r_valid;
    logic [ST_W-1:0]       r_status;
    logic [ELEM_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]      r_count, r_free;
    logic                  r_full, r_empty;
    logic                  take;

    assign take       = !r_valid || !i_stall;
    assign o_s1_stall = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_s1_valid) begin
            r_status <= i_s1_info.status;
            r_data   <= i_s1_info.rd_ok ? i_s1_data : '0;
            r_count  <= i_s1_count;
            r_free   <= i_s1_free;
            r_full   <= i_s1_info.full;
            r_empty  <= i_s1_info.empty;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_data_out      = r_data;
    assign o_count         = r_count;
    assign o_free_space    = r_free;
    assign o_is_full_flag  = r_full;
    assign o_is_empty_flag = r_empty;

endmodule

>>> sv/circular_fifo_queue_unit.sv
// Circular FIFO queue with a programmable ring size.
//
// Request channel: i_valid / o_stall carry one word per operation (operation,
// data_in, position). Result channel: o_valid / i_stall return exactly one
// word per request with status, data, count, free space and full/empty flags
// as they stand after the operation. Results come back in request order.
//
// Throughput is one word per cycle while the receiver does not hold i_stall.
// The queue state updates and the ring storage is read at the edge that
// accepts the request; the registered read data then moves into the output
// register together with the status and flags, and o_valid rises with it.
//
// When the receiver holds i_stall, the output word holds and the word behind
// it waits in the core stage; o_stall rises only once both stages are full.
//
// Reset empties the queue and sets the capacity register to 64. Writing the
// capacity register over the APB port also empties the queue; write it only
// while no request is in flight. Ring slots hold no reset value.
module circular_fifo_queue_unit #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = cfq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfq_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfq_pkg::PDATA_W-1:0]  pwdata,
    output logic [cfq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // Request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [cfq_pkg::OP_W-1:0]     i_operation,
    input  logic [ELEM_WIDTH-1:0]        i_data_in,
    input  logic [$clog2(DEPTH)-1:0]     i_position,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cfq_pkg::ST_W-1:0]     o_status,
    output logic [ELEM_WIDTH-1:0]        o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [$clog2(DEPTH+1)-1:0]   o_free_space,
    output logic                         o_is_full_flag,
    output logic                         o_is_empty_flag
);
    import cfq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] cap;
    logic             cap_wr;
    logic             s1_valid, s1_stall;
    t_s1_info         s1_info;
    logic [CNT_W-1:0] s1_count, s1_free;
    logic [ELEM_WIDTH-1:0] s1_data;

    cfq_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cap    (cap),
        .o_cap_wr (cap_wr)
    );

    // Queue state, ring storage and the first result stage.
    cfq_core #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (cap),
        .i_cap_wr    (cap_wr),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_data_in   (i_data_in),
        .i_position  (i_position),
        .o_s1_valid  (s1_valid),
        .i_s1_stall  (s1_stall),
        .o_s1_info   (s1_info),
        .o_s1_count  (s1_count),
        .o_s1_free   (s1_free),
        .o_s1_data   (s1_data)
    );

    // Output register facing the receiver.
    cfq_out #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (s1_valid),
        .o_s1_stall      (s1_stall),
        .i_s1_info       (s1_info),
        .i_s1_count      (s1_count),
        .i_s1_free       (s1_free),
        .i_s1_data       (s1_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_count         (o_count),
        .o_free_space    (o_free_space),
        .o_is_full_flag  (o_is_full_flag),
        .o_is_empty_flag (o_is_empty_flag)
    );

endmodule

>>> sv/cfq_chk.sv
module cfq_chk #(
    parameter int ELEM_WIDTH = cfq_pkg::ELEM_WIDTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [cfq_pkg::ST_W-1:0] o_status,
    input logic [ELEM_WIDTH-1:0]    o_data_out,
    input logic                     o_is_full_flag,
    input logic                     o_is_empty_flag
);
    import cfq_pkg::*;

    // No result may appear in the cycle right after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A failed operation never returns data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_data_out == '0))
        else $error("data returned with a failing status");

    // Status and flags agree: an empty status reports an empty queue,
    // a full status a full one.
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status != ST_EMPTY || o_is_empty_flag)
                  && (o_status != ST_FULL || o_is_full_flag)))
        else $error("status disagrees with full/empty flags");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_out) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind circular_fifo_queue_unit cfq_chk #(.ELEM_WIDTH(ELEM_WIDTH)) u_cfq_chk (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import cfq_pkg::*;

    // Sizes seen at the ports of the queue.
    localparam int DEPTH     = DEPTH_DEF;
    localparam int ELEM_W    = ELEM_WIDTH_DEF;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int PTR_W     = $clog2(DEPTH);

    // Operation codes 6 and 7 are not defined by the queue, which must ignore them.
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    // Length of the receiver's long hold-off, in clock cycles.
    localparam int LONG_HOLD     = 300;
    // Cycles to let pass after the last result before touching the register.
    localparam int SETTLE_CYCLES = 4;
    // Hard stop for a hung run.
    localparam int RUN_LIMIT_NS  = 3_000_000;

    // One request word as offered on the input channel.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ELEM_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } t_request_word;

    // One result word as expected on the output channel.
    typedef struct {
        logic [ST_W-1:0]   status;
        logic [ELEM_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  free_space;
        logic              full;
        logic              empty;
    } t_result_word;

    // Every input of the queue starts at a known value.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [OP_W-1:0]      i_operation = '0;
    logic [ELEM_W-1:0]    i_data_in   = '0;
    logic [POS_W-1:0]     i_position  = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [ST_W-1:0]      o_status;
    logic [ELEM_W-1:0]    o_data_out;
    logic [CNT_W-1:0]     o_count;
    logic [CNT_W-1:0]     o_free_space;
    logic                 o_is_full_flag;
    logic                 o_is_empty_flag;

    circular_fifo_queue_unit #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_data_in       (i_data_in),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_count         (o_count),
        .o_free_space    (o_free_space),
        .o_is_full_flag  (o_is_full_flag),
        .o_is_empty_flag (o_is_empty_flag)
    );

    // Words waiting to be offered, and results waiting to come back.
    t_request_word pending_words[$];
    t_result_word  expected_results[$];

    // Idle rates in percent for the sender and the receiver. The stimulus
    // drops them to zero for one phase so that the queue also sees an
    // unbroken stream.
    int send_idle_pct = 32;
    int recv_idle_pct = 32;

    // Long receiver hold-offs are asked for by the stimulus and served by
    // the receiver, which counts the stalled cycles itself.
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    int err_count    = 0;

    // Shadow copy of the queue: ring contents, pointers, full mark, count
    // and the raw capacity register as last written.
    logic [ELEM_W-1:0] ring_copy [DEPTH];
    logic [PTR_W-1:0]  q_head  = '0;
    logic [PTR_W-1:0]  q_tail  = '0;
    logic              q_full  = 1'b0;
    logic [CNT_W-1:0]  q_count = '0;
    logic [CNT_W-1:0]  cap_reg = CAP_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The register holds the raw value, but the ring never uses fewer than
    // one slot nor more than DEPTH slots.
    function automatic int eff_capacity();
        if (cap_reg == '0) begin
            return 1;
        end
        if (int'(cap_reg) > DEPTH) begin
            return DEPTH;
        end
        return int'(cap_reg);
    endfunction

    // Applies one request word to the shadow queue and returns the result
    // word that the queue must produce for it.
    function automatic t_result_word queue_apply(input t_request_word w);
        t_result_word r;
        int eff;
        int slot;
        eff = eff_capacity();
        r.status = ST_OK;
        r.data   = '0;
        case (w.op)
            OP_ENQ: begin
                if (q_full || int'(q_count) >= eff) begin
                    r.status = ST_FULL;
                end else begin
                    ring_copy[q_tail] = w.data;
                    q_tail  = (int'(q_tail) + 1 >= eff) ? '0 : q_tail + 1'b1;
                    q_count = q_count + 1'b1;
                    q_full  = (int'(q_count) == eff);
                end
            end
            OP_DEQ: begin
                if (q_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data  = ring_copy[q_head];
                    q_head  = (int'(q_head) + 1 >= eff) ? '0 : q_head + 1'b1;
                    q_count = q_count - 1'b1;
                    q_full  = 1'b0;
                end
            end
            OP_FRONT: begin
                if (q_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = ring_copy[q_head];
                end
            end
            OP_REAR: begin
                if (q_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // The newest word sits one slot behind the tail, wrapping
                    // back to the last slot in use.
                    slot   = (q_tail == '0) ? eff - 1 : int'(q_tail) - 1;
                    r.data = ring_copy[slot];
                end
            end
            OP_READ: begin
                if (int'(w.pos) >= int'(q_count)) begin
                    r.status = ST_RANGE;
                end else begin
                    slot = int'(q_head) + int'(w.pos);
                    if (slot >= eff) begin
                        slot = slot - eff;
                    end
                    r.data = ring_copy[slot];
                end
            end
            OP_CLR: begin
                q_head  = '0;
                q_tail  = '0;
                q_full  = 1'b0;
                q_count = '0;
            end
            default: begin
            end
        endcase
        r.count      = q_count;
        r.free_space = CNT_W'(eff - int'(q_count));
        r.full       = (int'(q_count) == eff);
        r.empty      = (q_count == '0);
        return r;
    endfunction

    // Sender. A word is taken by the queue at an edge where i_valid is high
    // and o_stall is low; the expected result is worked out right there.
    // A new word is only offered once the previous one has gone, and the
    // decision to idle never looks at o_stall.
    always @(posedge i_clk) begin : sender
        t_request_word sent;
        t_request_word next_word;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sent.op   = i_operation;
                sent.data = i_data_in;
                sent.pos  = i_position;
                expected_results.push_back(queue_apply(sent));
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= next_word.op;
                    i_data_in   <= next_word.data;
                    i_position  <= next_word.pos;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
                               input logic [ELEM_W-1:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Receiver. Each result word taken is held against the oldest expected
    // one, field by field. The stall for the next cycle is chosen at random,
    // or held high for a long stretch when the stimulus asks for it.
    always @(posedge i_clk) begin : receiver
        t_result_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result word with none expected, status %h data %h",
                             $time, o_status, o_data_out);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", ELEM_W'(want.status), ELEM_W'(o_status));
                    check_field("data_out", want.data, o_data_out);
                    check_field("count", ELEM_W'(want.count), ELEM_W'(o_count));
                    check_field("free_space", ELEM_W'(want.free_space),
                                ELEM_W'(o_free_space));
                    check_field("is_full_flag", ELEM_W'(want.full), ELEM_W'(o_is_full_flag));
                    check_field("is_empty_flag", ELEM_W'(want.empty),
                                ELEM_W'(o_is_empty_flag));
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else if (holds_served < holds_asked) begin
                holds_served = holds_served + 1;
                hold_left    = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] data,
                              input logic [POS_W-1:0] pos);
        t_request_word w;
        w.op   = op;
        w.data = data;
        w.pos  = pos;
        pending_words.push_back(w);
    endtask

    // Returns once every word has been taken and every result has come back,
    // plus a few cycles so the two-stage pipe is surely empty.
    task automatic wait_drained();
        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the capacity register, reads it back, and empties the shadow
    // queue the way the hardware does on a write.
    task automatic program_capacity(input logic [CAP_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_CAP, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = value;
        q_head  = '0;
        q_tail  = '0;
        q_full  = 1'b0;
        q_count = '0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("capacity readback", ELEM_W'(value), ELEM_W'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Queues n random words. fill_pct sets how often a word is an enqueue,
    // so a phase can push the queue towards full or towards empty. Read
    // positions are drawn half the time within the ring in use, where hits
    // are likely, and otherwise anywhere in the field.
    task automatic queue_random_mix(input int n, input int fill_pct);
        logic [OP_W-1:0] op;
        int pick;
        int eff;
        eff = eff_capacity();
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < fill_pct) begin
                op = OP_ENQ;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    op = OP_DEQ;
                end else if (pick < 57) begin
                    op = OP_FRONT;
                end else if (pick < 69) begin
                    op = OP_REAR;
                end else if (pick < 91) begin
                    op = OP_READ;
                end else if (pick < 96) begin
                    op = OP_CLR;
                end else if (pick < 98) begin
                    op = OP_RSVD6;
                end else begin
                    op = OP_RSVD7;
                end
            end
            queue_word(op, $urandom(), $urandom_range(0, 1) != 0 ?
                       POS_W'($urandom_range(0, DEPTH - 1)) : POS_W'($urandom_range(0, eff - 1)));
        end
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] cap_plan [13];
        int phase;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset capacity of 64. An empty queue must
        // refuse every read, also a position read at slot 0, and ignore
        // the two undefined operation codes.
        queue_word(OP_DEQ, '0, '0);
        queue_word(OP_FRONT, '0, '0);
        queue_word(OP_REAR, '0, '0);
        queue_word(OP_READ, '0, '0);
        queue_word(OP_RSVD6, '1, '1);
        queue_word(OP_RSVD7, '1, '1);
        queue_word(OP_ENQ, '1, '0);
        queue_word(OP_ENQ, '0, '1);
        queue_word(OP_ENQ, 32'hA5A5_A5A5, '0);
        queue_word(OP_FRONT, '0, '0);
        queue_word(OP_REAR, '0, '0);
        queue_word(OP_READ, '0, 6'd2);
        queue_word(OP_READ, '0, 6'd3);
        queue_word(OP_READ, '0, '1);
        queue_word(OP_DEQ, '0, '0);
        queue_word(OP_CLR, '1, '0);
        queue_word(OP_DEQ, '0, '0);
        wait_drained();

        // A one-slot ring is full after a single enqueue, and the rear and
        // the front are then the same word.
        program_capacity(7'd1);
        queue_word(OP_ENQ, 32'h1234_5678, '0);
        queue_word(OP_ENQ, 32'h8765_4321, '0);
        queue_word(OP_FRONT, '0, '0);
        queue_word(OP_REAR, '0, '0);
        queue_word(OP_READ, '0, 6'd0);
        queue_word(OP_READ, '0, 6'd1);
        queue_word(OP_DEQ, '0, '0);
        queue_word(OP_DEQ, '0, '0);
        wait_drained();

        // Random phases, one per capacity setting. Zero must act as one and
        // anything above 64 as 64; the small rings wrap and fill often.
        cap_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd3, 7'd64,
                     7'd17, 7'd5, 7'd63, 7'd40, 7'd1};
        cap_plan[12] = CAP_W'($urandom_range(1, 127));

        for (phase = 0; phase < 13; phase++) begin
            program_capacity(cap_plan[phase]);

            // One phase runs with no idling on either side.
            if (phase == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 32;
                recv_idle_pct = 32;
            end

            // Here the receiver stops for a long stretch while words keep
            // coming, so both pipe stages fill and o_stall must rise.
            if (phase == 5) begin
                holds_asked = holds_asked + 1;
            end

            // Fill the full 64-slot ring past the top, then read its far end.
            if (phase == 7) begin
                repeat (DEPTH + 1) queue_word(OP_ENQ, $urandom(), POS_W'($urandom()));
                queue_word(OP_READ, '0, '1);
                queue_word(OP_READ, '0, '0);
                queue_word(OP_REAR, '0, '0);
                queue_word(OP_FRONT, '0, '0);
            end

            queue_random_mix(50, 65);

            // The sender pauses here until every result is back.
            if (phase == 2) begin
                wait_drained();
            end

            queue_random_mix(50, 30);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/cfq_pkg.sv
sv/cfq_regs.sv
sv/cfq_core.sv
sv/cfq_out.sv
sv/circular_fifo_queue_unit.sv
sv/cfq_chk.sv
verif/tb_top.sv
